[hdl/u8u16_pkg.sv]
package u8u16_pkg;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_BMP  = 2'd1;
  localparam logic [1:0] KIND_PAIR = 2'd2;

  localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
  localparam logic [15:0] HIGH_SURR    = 16'hD800;
  localparam logic [15:0] LOW_SURR     = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [20:0] MAX_SCALAR   = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST   = 21'h00D800;
  localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
  localparam logic [20:0] MIN_TWO_BYTE = 21'h000080;
  localparam logic [20:0] MIN_THREE    = 21'h000800;

  typedef struct packed {
    logic [2:0]  rep_cnt;
    logic [1:0]  kind;
    logic [20:0] value;
  } desc_t;

endpackage

[hdl/u8u16_front.sv]
module u8u16_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_final,
  input  logic                 q_full,
  output logic                 q_push,
  output u8u16_pkg::desc_t     q_desc
);

  logic [1:0]  exp_len;
  logic [1:0]  seen;
  logic [20:0] pv;
  logic [1:0]  exp_len_next;
  logic [1:0]  seen_next;
  logic [20:0] pv_next;
  logic [20:0] pv_cat;
  logic [2:0]  rep;
  logic [1:0]  kind;
  logic [20:0] value;

  function automatic logic scalar_ok(input logic [1:0] need, input logic [20:0] v);
    logic ok;
    ok = 1'b1;
    if (need == 2'd1 && v < u8u16_pkg::MIN_TWO_BYTE) ok = 1'b0;
    if (need == 2'd2 && v < u8u16_pkg::MIN_THREE) ok = 1'b0;
    if (need == 2'd3 && v < u8u16_pkg::SUPP_BASE) ok = 1'b0;
    if (v >= u8u16_pkg::SURR_FIRST && v <= u8u16_pkg::SURR_LAST) ok = 1'b0;
    if (v > u8u16_pkg::MAX_SCALAR) ok = 1'b0;
    return ok;
  endfunction

  assign in_ready = !q_full;
  assign pv_cat   = {pv[14:0], in_byte[5:0]};

  always_comb begin
    exp_len_next = exp_len;
    seen_next    = seen;
    pv_next      = pv;
    rep          = 3'd0;
    kind         = u8u16_pkg::KIND_NONE;
    value        = '0;
    if (exp_len != 2'd0 && in_byte[7:6] == 2'b10) begin
      if (seen + 2'd1 == exp_len) begin
        exp_len_next = 2'd0;
        seen_next    = 2'd0;
        pv_next      = '0;
        if (scalar_ok(exp_len, pv_cat)) begin
          kind  = (pv_cat < u8u16_pkg::SUPP_BASE) ? u8u16_pkg::KIND_BMP : u8u16_pkg::KIND_PAIR;
          value = pv_cat;
        end else begin
          rep = {1'b0, exp_len} + 3'd1;
        end
      end else begin
        seen_next = seen + 2'd1;
        pv_next   = pv_cat;
      end
    end else begin
      rep          = (exp_len != 2'd0) ? {1'b0, seen} + 3'd1 : 3'd0;
      exp_len_next = 2'd0;
      seen_next    = 2'd0;
      pv_next      = '0;
      if (!in_byte[7]) begin
        kind  = u8u16_pkg::KIND_BMP;
        value = {13'd0, in_byte};
      end else if (in_byte[7:5] == 3'b110) begin
        exp_len_next = 2'd1;
        pv_next      = {16'd0, in_byte[4:0]};
      end else if (in_byte[7:4] == 4'b1110) begin
        exp_len_next = 2'd2;
        pv_next      = {17'd0, in_byte[3:0]};
      end else if (in_byte[7:3] == 5'b11110) begin
        exp_len_next = 2'd3;
        pv_next      = {18'd0, in_byte[2:0]};
      end else begin
        rep = rep + 3'd1;
      end
    end
    // flush an unfinished tail at the end of the string
    if (in_final && exp_len_next != 2'd0) begin
      rep          = rep + {1'b0, seen_next} + 3'd1;
      exp_len_next = 2'd0;
      seen_next    = 2'd0;
      pv_next      = '0;
    end
  end

  assign q_desc.rep_cnt = rep;
  assign q_desc.kind    = kind;
  assign q_desc.value   = value;
  assign q_push = in_valid && in_ready && (rep != 3'd0 || kind != u8u16_pkg::KIND_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= 2'd0;
      seen    <= 2'd0;
      pv      <= '0;
    end else if (in_valid && in_ready) begin
      exp_len <= exp_len_next;
      seen    <= seen_next;
      pv      <= pv_next;
    end
  end

  a_seen_below_len: assert property (@(posedge clk) disable iff (rst)
    exp_len != 2'd0 |-> seen < exp_len)
    else $error("continuation count reached sequence length");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    exp_len == 2'd0 |-> seen == 2'd0 && pv == 21'd0)
    else $error("sequence state left over with nothing pending");

endmodule

[hdl/u8u16_queue.sv]
module u8u16_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8u16_pkg::desc_t  push_desc,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output u8u16_pkg::desc_t  head_desc
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u8u16_pkg::desc_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_desc  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

[hdl/u8u16_back.sv]
module u8u16_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              desc_valid,
  input  u8u16_pkg::desc_t  desc,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_unit,
  output logic              out_replaced,
  output logic              out_last
);

  logic [1:0]  idx;
  logic [2:0]  total;
  logic [19:0] offs;
  logic [15:0] unit;
  logic        unit_rep;
  logic        is_last;
  logic        load;

  always_comb begin
    unique case (desc.kind)
      u8u16_pkg::KIND_BMP:  total = desc.rep_cnt + 3'd1;
      u8u16_pkg::KIND_PAIR: total = desc.rep_cnt + 3'd2;
      default:              total = desc.rep_cnt;
    endcase
  end

  assign offs    = 20'(desc.value - u8u16_pkg::SUPP_BASE);
  assign is_last = ({1'b0, idx} + 3'd1 == total);
  assign load    = desc_valid && (!out_valid || out_ready);
  assign pop     = load && is_last;

  always_comb begin
    if ({1'b0, idx} < desc.rep_cnt) begin
      unit     = u8u16_pkg::REPL_UNIT;
      unit_rep = 1'b1;
    end else if ({1'b0, idx} == desc.rep_cnt) begin
      unit     = (desc.kind == u8u16_pkg::KIND_BMP) ? desc.value[15:0]
               : u8u16_pkg::HIGH_SURR + {6'd0, offs[19:10]};
      unit_rep = 1'b0;
    end else begin
      unit     = u8u16_pkg::LOW_SURR + {6'd0, offs[9:0]};
      unit_rep = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      idx       <= is_last ? 2'd0 : idx + 2'd1;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_unit     <= unit;
      out_replaced <= unit_rep;
      out_last     <= is_last;
    end
  end

  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> {1'b0, idx} < total)
    else $error("unit index past the end of its run");

  a_pop_ends_run: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && out_last)
    else $error("descriptor released without its last unit");

endmodule

[hdl/utf8_to_utf16_decoder_unit.sv]
// channel | dir | tdata                 | tuser        | tlast
// s_axis  | in  | [7:0] byte_in         | -            | final_byte
// m_axis  | out | [15:0] code_unit      | [0] replaced | run_last
//
// Takes one byte a cycle while the queue is not full; each byte turns into a
// descriptor of 0..4 units. The unit sequencer emits one code unit a cycle while
// m_axis_tready is high, so a byte giving n units holds the output side until
// all n are sent; the descriptor queue absorbs bursts.
// rst is synchronous and clears the sequence state, queue and output stage.
// Either side may stall freely; s_axis_tready falls only when the queue is full.
module utf8_to_utf16_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic        m_axis_tuser,   // [0] replaced
  output logic        m_axis_tlast
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  u8u16_pkg::desc_t push_desc;
  u8u16_pkg::desc_t head_desc;

  u8u16_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_final (s_axis_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  u8u16_back u_back (
    .clk          (clk),
    .rst          (rst),
    .desc_valid   (q_valid),
    .desc         (head_desc),
    .pop          (q_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_unit     (m_axis_tdata),
    .out_replaced (m_axis_tuser),
    .out_last     (m_axis_tlast)
  );

endmodule
